/* hdl/line_raster_color_interp_macros.svh */
// Assertion macros for the line rasteriser.
`ifndef LINE_RASTER_COLOR_INTERP_MACROS_SVH
`define LINE_RASTER_COLOR_INTERP_MACROS_SVH
// Check that an antecedent implies a consequent on the next edge.
`define LRCI_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define LRCI_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

/* hdl/lrci_pkg.sv */
// Shared types and constants for the line rasteriser.
package lrci_pkg;
  localparam int COORD_BITS = 10;
  localparam int DIM_BITS = 11;
  localparam int CHAN_BITS = 8;
  localparam int CFG_IDX_BITS = 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET = 11'd640;
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 11'd480;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [7:0]            red0;
    logic [7:0]            green0;
    logic [7:0]            blue0;
    logic [7:0]            red1;
    logic [7:0]            green1;
    logic [7:0]            blue1;
  } request_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  in_frame;
    logic                  last_pixel;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ACTIVE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch endpoints and colours
    logic setup;     // order endpoints and derive deltas
    logic advance;   // emit a pixel and step
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic degenerate;
    logic last;
    logic busy;      // colour step division still running
  } status_t;
endpackage

/* hdl/lrci_ctrl.sv */
// Controller state machine for the line rasteriser.
module lrci_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  output logic              out_valid,
  input  logic              out_stall,
  input  lrci_pkg::status_t status,
  output lrci_pkg::cmd_t    cmd
);
  import lrci_pkg::*;

  state_t state, state_next;
  logic   out_free;
  logic   in_acc;

  assign out_free = !out_valid || !out_stall;
  // Hold requests during setup and colour division; a step waits for room in the output register.
  assign in_stall = (state == ST_SETUP) || status.busy ||
                    (in_command == CMD_STEP && state == ST_ACTIVE && !out_free);
  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_command == CMD_LOAD) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = status.degenerate ? ST_IDLE : ST_ACTIVE;
      end
      ST_ACTIVE: begin
        if (in_acc && in_command == CMD_LOAD) state_next = ST_SETUP;
        else if (in_acc && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.capture = in_acc && in_command == CMD_LOAD;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_ACTIVE: begin
        cmd.capture = in_acc && in_command == CMD_LOAD;
        cmd.advance = in_acc && in_command == CMD_STEP;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.advance) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule

/* hdl/lrci_lerp.sv */
// Colour channel interpolator: serial step division at line start, then running quotient and remainder.
module lrci_lerp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            init,
  input  logic                            advance,
  input  logic [7:0]                      from,
  input  logic [7:0]                      to,
  input  logic [lrci_pkg::COORD_BITS-1:0] delta,
  output logic [7:0]                      value,
  output logic                            busy
);
  import lrci_pkg::*;

  // q = floor(|to-from|*k/delta) and r the matching remainder; a falling channel
  // subtracts q and one more when r is non-zero, which rounds towards minus infinity.
  logic [8:0]            diff_mag;
  logic                  neg;
  logic [3:0]            div_count;
  logic [8:0]            div_bits;
  logic [8:0]            step_q;    // floor(|diff| / delta) is at most 255
  logic [COORD_BITS-1:0] step_r;
  logic [COORD_BITS:0]   delta_w;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   trial_minus;
  logic [8:0]            q;
  logic [COORD_BITS-1:0] r;
  logic [COORD_BITS:0]   r_sum;
  logic [COORD_BITS:0]   r_wrap;
  logic                  carry;
  logic                  round_up;

  assign delta_w = {1'b0, delta};
  assign neg = to < from;
  assign diff_mag = neg ? {1'b0, from} - {1'b0, to} : {1'b0, to} - {1'b0, from};

  // One restoring division bit per cycle, most significant bit first.
  assign trial = {step_r, div_bits[8]};
  assign trial_minus = trial - delta_w;

  assign r_sum = {1'b0, r} + {1'b0, step_r};
  assign carry = r_sum >= delta_w;
  assign r_wrap = r_sum - delta_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
      div_bits <= '0;
      step_q <= '0;
      step_r <= '0;
      q <= '0;
      r <= '0;
    end else if (init) begin
      div_count <= 4'd9;
      div_bits <= diff_mag;
      step_q <= '0;
      step_r <= '0;
      q <= '0;
      r <= '0;
    end else if (div_count != 4'd0) begin
      div_bits <= {div_bits[7:0], 1'b0};
      if (trial >= delta_w) begin
        step_r <= trial_minus[COORD_BITS-1:0];
        step_q <= {step_q[7:0], 1'b1};
      end else begin
        step_r <= trial[COORD_BITS-1:0];
        step_q <= {step_q[7:0], 1'b0};
      end
      div_count <= div_count - 4'd1;
    end else if (advance) begin
      q <= q + step_q + {8'd0, carry};
      r <= carry ? r_wrap[COORD_BITS-1:0] : r_sum[COORD_BITS-1:0];
    end
  end

  assign busy = init || (div_count != 4'd0);
  assign round_up = neg && (r != '0);
  assign value = neg ? from - q[7:0] - {7'd0, round_up} : from + q[7:0];
endmodule

/* hdl/lrci_datapath.sv */
// Datapath of the line rasteriser: endpoint setup, Bresenham step, colours.
module lrci_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  lrci_pkg::cmd_t                cmd,
  input  lrci_pkg::request_t            req,
  input  logic [lrci_pkg::DIM_BITS-1:0] frame_width,
  input  logic [lrci_pkg::DIM_BITS-1:0] frame_height,
  input  logic                          out_load,
  output lrci_pkg::status_t             status,
  output lrci_pkg::result_t             result
);
  import lrci_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EB = CB + 3;

  logic [CB-1:0] xs, ys, xe, ye;
  logic [23:0]   c0, c1;
  logic          steep;
  logic [CB-1:0] major_pos, major_stop, minor_pos, major_delta, minor_delta;
  logic          minor_down;
  logic signed [EB-1:0] step_error;
  logic [23:0]   color_from, color_to;
  logic          lerp_init;
  logic          busy_r, busy_g, busy_b;

  logic [CB-1:0] adx, ady, ma0, mi0, ma1, mi1, sma0, smi0, sma1, smi1;
  logic          s_steep;

  assign adx = (xe > xs) ? xe - xs : xs - xe;
  assign ady = (ye > ys) ? ye - ys : ys - ye;
  assign s_steep = ady > adx;
  assign ma0 = s_steep ? ys : xs;
  assign mi0 = s_steep ? xs : ys;
  assign ma1 = s_steep ? ye : xe;
  assign mi1 = s_steep ? xe : ye;
  assign sma0 = (ma0 > ma1) ? ma1 : ma0;
  assign smi0 = (ma0 > ma1) ? mi1 : mi0;
  assign sma1 = (ma0 > ma1) ? ma0 : ma1;
  assign smi1 = (ma0 > ma1) ? mi0 : mi1;

  assign status.degenerate = (sma1 == sma0);
  assign status.last = (major_pos + CB'(1)) == major_stop;
  assign status.busy = busy_r || busy_g || busy_b;

  logic [CB-1:0] px, py;
  logic signed [EB-1:0] err_sub;
  logic [7:0] r_v, g_v, b_v;

  assign px = steep ? minor_pos : major_pos;
  assign py = steep ? major_pos : minor_pos;
  assign err_sub = step_error - $signed({2'b00, minor_delta, 1'b0});

  // Start the colour division once the setup registers hold the new line.
  always_ff @(posedge clk) begin
    if (rst) lerp_init <= 1'b0;
    else lerp_init <= cmd.setup;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xs <= req.x_start;
      ys <= req.y_start;
      xe <= req.x_end;
      ye <= req.y_end;
      c0 <= {req.red0, req.green0, req.blue0};
      c1 <= {req.red1, req.green1, req.blue1};
    end
    if (cmd.setup) begin
      steep <= s_steep;
      color_from <= s_steep ? c1 : c0;
      color_to <= s_steep ? c0 : c1;
      major_pos <= sma0;
      major_stop <= sma1;
      minor_pos <= smi0;
      minor_down <= smi0 > smi1;
      major_delta <= sma1 - sma0;
      minor_delta <= (smi0 > smi1) ? smi0 - smi1 : smi1 - smi0;
      step_error <= $signed({3'b000, sma1 - sma0});
    end
    if (cmd.advance) begin
      if (err_sub < 0) begin
        minor_pos <= minor_down ? minor_pos - CB'(1) : minor_pos + CB'(1);
        step_error <= err_sub + $signed({2'b00, major_delta, 1'b0});
      end else begin
        step_error <= err_sub;
      end
      major_pos <= major_pos + CB'(1);
    end
    if (out_load) begin
      result.pixel_x <= px;
      result.pixel_y <= py;
      result.red <= r_v;
      result.green <= g_v;
      result.blue <= b_v;
      result.in_frame <= ({1'b0, px} < frame_width) && ({1'b0, py} < frame_height);
      result.last_pixel <= status.last;
    end
  end

  lrci_lerp u_red (
    .clk(clk), .rst(rst), .init(lerp_init), .advance(cmd.advance),
    .from(color_from[23:16]), .to(color_to[23:16]), .delta(major_delta), .value(r_v),
    .busy(busy_r)
  );
  lrci_lerp u_green (
    .clk(clk), .rst(rst), .init(lerp_init), .advance(cmd.advance),
    .from(color_from[15:8]), .to(color_to[15:8]), .delta(major_delta), .value(g_v),
    .busy(busy_g)
  );
  lrci_lerp u_blue (
    .clk(clk), .rst(rst), .init(lerp_init), .advance(cmd.advance),
    .from(color_from[7:0]), .to(color_to[7:0]), .delta(major_delta), .value(b_v),
    .busy(busy_b)
  );
endmodule

/* hdl/line_raster_color_interp.sv */
// Line rasteriser with Bresenham stepping and per-channel colour interpolation.
// A load request stalls the input through the setup state, the division start and the
//   serial step division, which the three colour channels run in parallel.
// One pixel per cycle once set up and unstalled; a step's pixel is out the next cycle.
// Colour runs as a running quotient and remainder per channel, no divider in the loop.
// Reset: synchronous, active high; clears control, frame size to 640 by 480.
module line_raster_color_interp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lrci_pkg::request_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lrci_pkg::result_t                   out_data,
  input  logic                                cfg_write,
  input  logic [lrci_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lrci_pkg::DIM_BITS-1:0]       cfg_data
);
  import lrci_pkg::*;
  `include "line_raster_color_interp_macros.svh"

  logic [DIM_BITS-1:0] frame_width, frame_height;
  cmd_t    cmd;
  status_t status;

  // Frame registers: the user must write them only while idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lrci_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_data.command), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd)
  );

  // Load the output register on each pixel step.
  lrci_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(in_data), .frame_width(frame_width),
    .frame_height(frame_height), .out_load(cmd.advance), .status(status), .result(out_data)
  );

  `LRCI_ASSERT_NEXT(a_step_gives_pixel, clk, rst, cmd.advance, out_valid, "step lost its pixel")
  `LRCI_ASSERT_NOW(a_no_double_cmd, clk, rst, cmd.setup, !cmd.advance && !cmd.capture, "setup overlaps")
  `LRCI_ASSERT_NEXT(a_setup_stalls, clk, rst, cmd.capture, in_stall, "setup not stalled")
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the line rasteriser with colour interpolation.
module tb;
  import lrci_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int REQ_BITS = $bits(request_t);

  // Pixel predictor: its own copy of the line state and the frame size.
  class pixel_scoreboard;
    logic [10:0] frame_w = 11'd640;
    logic [10:0] frame_h = 11'd480;
    bit          active;
    bit          steep;
    bit          down;
    int          pos;
    int          origin;
    int          stop;
    int          minor;
    int          err;
    int          dmaj;
    int          dmin;
    logic [23:0] col_from;
    logic [23:0] col_to;
    result_t     pending[$];
    int          fails;
    int          pixels;
    int          loads;

    function logic [7:0] blend(logic [7:0] from, logic [7:0] to, int k, int d);
      int num;
      int q;
      if (d == 0) return from;
      num = (int'(to) - int'(from)) * k;
      if (num >= 0) q = num / d;
      else q = -((-num + d - 1) / d);
      return 8'(int'(from) + q);
    endfunction

    // Note an accepted request and queue the pixel it causes, if any.
    function void note_request(request_t r);
      int a0, b0, a1, b1, t, adx, ady, k;
      result_t p;
      bit last;
      if (r.command == CMD_LOAD) begin
        loads++;
        adx = r.x_end > r.x_start ? r.x_end - r.x_start : r.x_start - r.x_end;
        ady = r.y_end > r.y_start ? r.y_end - r.y_start : r.y_start - r.y_end;
        steep = ady > adx;
        if (steep) begin
          a0 = r.y_start; b0 = r.x_start; a1 = r.y_end; b1 = r.x_end;
          col_from = {r.red1, r.green1, r.blue1};
          col_to = {r.red0, r.green0, r.blue0};
        end else begin
          a0 = r.x_start; b0 = r.y_start; a1 = r.x_end; b1 = r.y_end;
          col_from = {r.red0, r.green0, r.blue0};
          col_to = {r.red1, r.green1, r.blue1};
        end
        if (a0 > a1) begin
          t = a0; a0 = a1; a1 = t;
          t = b0; b0 = b1; b1 = t;
        end
        origin = a0; pos = a0; stop = a1; minor = b0;
        down = b0 > b1;
        dmaj = a1 - a0;
        dmin = down ? b0 - b1 : b1 - b0;
        err = dmaj;
        active = dmaj != 0;
        return;
      end
      if (!active) return;
      k = pos - origin;
      last = (pos + 1) == stop;
      p.pixel_x = steep ? minor[9:0] : pos[9:0];
      p.pixel_y = steep ? pos[9:0] : minor[9:0];
      p.red = blend(col_from[23:16], col_to[23:16], k, dmaj);
      p.green = blend(col_from[15:8], col_to[15:8], k, dmaj);
      p.blue = blend(col_from[7:0], col_to[7:0], k, dmaj);
      p.in_frame = ({1'b0, p.pixel_x} < frame_w) && ({1'b0, p.pixel_y} < frame_h);
      p.last_pixel = last;
      pending.insert(pending.size(), p);
      err -= 2 * dmin;
      if (err < 0) begin
        minor = down ? (minor - 1) & 1023 : (minor + 1) & 1023;
        err += 2 * dmaj;
      end
      pos = (pos + 1) & 1023;
      if (last) active = 0;
    endfunction

    function void check_pixel(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("pixel with none expected: %p", got);
        fails++;
        return;
      end
      want = pending.pop_front();
      pixels++;
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x expected %0d got %0d", want.pixel_x, got.pixel_x); fails++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y expected %0d got %0d", want.pixel_y, got.pixel_y); fails++;
      end
      if (got.red !== want.red) begin
        $error("red expected %0d got %0d", want.red, got.red); fails++;
      end
      if (got.green !== want.green) begin
        $error("green expected %0d got %0d", want.green, got.green); fails++;
      end
      if (got.blue !== want.blue) begin
        $error("blue expected %0d got %0d", want.blue, got.blue); fails++;
      end
      if (got.in_frame !== want.in_frame) begin
        $error("in_frame expected %0d got %0d", want.in_frame, got.in_frame); fails++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $error("last_pixel expected %0d got %0d", want.last_pixel, got.last_pixel); fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  request_t    in_data;
  logic        out_valid;
  logic        out_stall;
  result_t     out_data;
  logic        cfg_write;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [DIM_BITS-1:0]     cfg_data;

  pixel_scoreboard board = new();
  bit          calm;        // no idling in the closing stretch
  int          quiet_cycles = 0;

  line_raster_color_interp dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both handshakes at the rising edge; watch for a hung pipeline.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_request(in_data);
      if (out_valid && !out_stall) board.check_pixel(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_CYCLES);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: stall in random bursts, changed on the falling edge only.
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 11);
        out_stall = 1'b1;
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Offer one request and hold it until accepted; sometimes idle first.
  task automatic send_request(request_t r);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_line(int xs, int ys, int xe, int ye, logic [23:0] c0, logic [23:0] c1);
    request_t r;
    r = '0;
    r.command = CMD_LOAD;
    r.x_start = xs[9:0]; r.y_start = ys[9:0];
    r.x_end = xe[9:0]; r.y_end = ye[9:0];
    {r.red0, r.green0, r.blue0} = c0;
    {r.red1, r.green1, r.blue1} = c1;
    send_request(r);
  endtask

  // A step carries random noise in the unused load fields.
  task automatic step_line(int n);
    request_t r;
    repeat (n) begin
      r = request_t'(REQ_BITS'({$urandom, $urandom, $urandom}));
      r.command = CMD_STEP;
      send_request(r);
    end
  endtask

  task automatic random_line(int span);
    int xs, ys;
    xs = $urandom_range(0, 1023);
    ys = $urandom_range(0, 1023);
    load_line(xs, ys,
              $urandom_range(0, 1) ? xs + $urandom_range(0, span) : xs - $urandom_range(0, span),
              $urandom_range(0, 1) ? ys + $urandom_range(0, span) : ys - $urandom_range(0, span),
              24'($urandom), 24'($urandom));
  endtask

  // Drain, let setup and the colour division settle, then write a frame register.
  task automatic write_frame(logic [CFG_IDX_BITS-1:0] idx, int value);
    in_valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (14) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value[DIM_BITS-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_FRAME_WIDTH) board.frame_w = value[10:0];
    else board.frame_h = value[10:0];
  endtask

  initial begin
    int phase;
    int sent;
    int steps;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: step while idle, extremes, both orders, steep and shallow, reload.
    step_line(2);
    load_line(0, 0, 1023, 1023, 24'h000000, 24'hFFFFFF);
    step_line(3);
    load_line(1023, 0, 0, 5, 24'hFFFFFF, 24'h000000);
    step_line(4);
    load_line(5, 1023, 8, 0, 24'h12F0A5, 24'hFF00FF);
    step_line(3);
    load_line(700, 600, 700, 600, 24'h808080, 24'h101010);     // degenerate point
    step_line(1);
    load_line(630, 470, 650, 490, 24'hFF0000, 24'h00FF00);     // crosses frame edge
    step_line(22);
    load_line(10, 10, 10, 13, 24'h0000FF, 24'h00FF00);         // vertical, whole line
    step_line(4);

    // Random phases across frame sizes, extremes included.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_frame(REG_FRAME_WIDTH, 1); write_frame(REG_FRAME_HEIGHT, 1024); end
        1: begin write_frame(REG_FRAME_WIDTH, 1024); write_frame(REG_FRAME_HEIGHT, 1); end
        2: begin write_frame(REG_FRAME_WIDTH, 0); write_frame(REG_FRAME_HEIGHT, 0); end
        3: begin write_frame(REG_FRAME_WIDTH, 2047); write_frame(REG_FRAME_HEIGHT, 2047); end
        4: begin
          write_frame(REG_FRAME_WIDTH, $urandom_range(1, 1024));
          write_frame(REG_FRAME_HEIGHT, $urandom_range(1, 1024));
        end
        default: calm = 1'b1;
      endcase
      sent = 0;
      while (sent < 92) begin
        random_line($urandom_range(0, 3) == 0 ? 1023 : 12);
        steps = $urandom_range(0, 16);
        step_line(steps);
        sent += steps + 1;
      end
    end

    in_valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("covered %0d loads and %0d pixels over six frame settings",
             board.loads, board.pixels);
    if (board.fails == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
